// ----- src/dq_pkg.sv -----
package dq_pkg;

  // Widths of the item fields
  localparam int unsigned WordW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 7;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [OpW-1:0]          op_t;
  typedef logic [StatusW-1:0]      status_t;
  typedef logic [FillW-1:0]        fill_t;

  // Operation codes
  localparam op_t OP_PUSH_BACK  = 3'd0;
  localparam op_t OP_PUSH_FRONT = 3'd1;
  localparam op_t OP_POP_BACK   = 3'd2;
  localparam op_t OP_POP_FRONT  = 3'd3;
  localparam op_t OP_SHOW       = 3'd4;

  // Status codes
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

endpackage

// ----- src/dq_store.sv -----
module dq_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  dq_pkg::word_t wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output dq_pkg::word_t rdata_o
);

  dq_pkg::word_t mem [DEPTH];
  dq_pkg::word_t rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/dq_ctrl.sv -----
module dq_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  dq_pkg::op_t     operation_i,
  input  dq_pkg::word_t   value_i,
  output logic            strobe_o,
  output dq_pkg::status_t status_o,
  output dq_pkg::word_t   element_o,
  output dq_pkg::fill_t   fill_count_o,
  output logic            last_o,
  output logic            we_o,
  output logic [AW-1:0]   waddr_o,
  output dq_pkg::word_t   wdata_o,
  output logic            re_o,
  output logic [AW-1:0]   raddr_o,
  input  dq_pkg::word_t   rdata_i
);

  localparam int unsigned SW = CW + 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SHOW = 1'b1;

  logic            state_q, state_d;
  logic [AW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic            valid_q, valid_d;
  logic            show_q, show_d;
  logic            last_q, last_d;
  dq_pkg::status_t status_q, status_d;
  dq_pkg::fill_t   fill_q, fill_d;

  logic            accept;
  logic            full, empty;
  logic [SW-1:0]   back_sum;
  logic [AW-1:0]   back_slot;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    slot_inc = (p == AW'(CAPACITY - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
    slot_dec = (p == '0) ? AW'(CAPACITY - 1) : AW'(p - 1'b1);
  endfunction

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q == ST_SHOW);
  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = (count_q == '0);

  // Wrap front plus count into the slot behind the back word
  assign back_sum  = SW'(front_q) + SW'(count_q);
  assign back_slot = (back_sum >= SW'(CAPACITY)) ? AW'(back_sum - SW'(CAPACITY))
                                                 : AW'(back_sum);

  assign wdata_o = value_i;

  // Decode the item or advance the show walk
  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    rptr_d   = rptr_q;
    rem_d    = rem_q;
    valid_d  = 1'b0;
    show_d   = 1'b0;
    last_d   = 1'b1;
    status_d = dq_pkg::STAT_OK;
    fill_d   = dq_pkg::FillW'(count_q);
    we_o     = 1'b0;
    waddr_o  = back_slot;
    re_o     = 1'b0;
    raddr_o  = front_q;

    if (accept) begin
      case (operation_i)
        dq_pkg::OP_PUSH_BACK: begin
          valid_d = 1'b1;
          if (full) begin
            status_d = dq_pkg::STAT_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = back_slot;
            count_d = CW'(count_q + 1'b1);
            fill_d  = dq_pkg::FillW'(count_d);
          end
        end
        dq_pkg::OP_PUSH_FRONT: begin
          valid_d = 1'b1;
          if (full) begin
            status_d = dq_pkg::STAT_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = slot_dec(front_q);
            front_d = slot_dec(front_q);
            count_d = CW'(count_q + 1'b1);
            fill_d  = dq_pkg::FillW'(count_d);
          end
        end
        dq_pkg::OP_POP_BACK: begin
          valid_d = 1'b1;
          if (empty) begin
            status_d = dq_pkg::STAT_EMPTY;
          end else begin
            count_d = CW'(count_q - 1'b1);
            fill_d  = dq_pkg::FillW'(count_d);
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          valid_d = 1'b1;
          if (empty) begin
            status_d = dq_pkg::STAT_EMPTY;
          end else begin
            front_d = slot_inc(front_q);
            count_d = CW'(count_q - 1'b1);
            fill_d  = dq_pkg::FillW'(count_d);
          end
        end
        dq_pkg::OP_SHOW: begin
          if (empty) begin
            valid_d  = 1'b1;
            status_d = dq_pkg::STAT_EMPTY;
          end else begin
            re_o    = 1'b1;
            raddr_o = front_q;
            show_d  = 1'b1;
            last_d  = (count_q == CW'(1));
            rptr_d  = slot_inc(front_q);
            rem_d   = CW'(count_q - 1'b1);
            if (count_q != CW'(1)) begin
              state_d = ST_SHOW;
            end
          end
        end
        default: begin
          valid_d = 1'b1;
        end
      endcase
    end else if (state_q == ST_SHOW) begin
      // Read the next word, one per cycle, until none remain
      re_o    = 1'b1;
      raddr_o = rptr_q;
      show_d  = 1'b1;
      last_d  = (rem_q == CW'(1));
      rptr_d  = slot_inc(rptr_q);
      rem_d   = CW'(rem_q - 1'b1);
      if (rem_q == CW'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  // Hold pointers, count and the result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      rptr_q   <= '0;
      rem_q    <= '0;
      valid_q  <= 1'b0;
      show_q   <= 1'b0;
      last_q   <= 1'b0;
      status_q <= dq_pkg::STAT_OK;
      fill_q   <= '0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      rptr_q   <= rptr_d;
      rem_q    <= rem_d;
      valid_q  <= valid_d;
      show_q   <= show_d;
      last_q   <= last_d;
      status_q <= status_d;
      fill_q   <= fill_d;
    end
  end

  // Drive the result; shown words come straight from the read register
  assign strobe_o     = valid_q || show_q;
  assign status_o     = status_q;
  assign element_o    = show_q ? rdata_i : '0;
  assign fill_count_o = fill_q;
  assign last_o       = last_q;

endmodule

// ----- src/double_ended_queue_core.sv -----
// Double-ended queue of signed 32-bit words in a circular single-port-read memory.
// Push, pop and unused codes: result registered, in the cycle after start; one item per cycle while not busy.
// Show of N words: N results on consecutive cycles, the first in the cycle after start;
// busy stays high while words remain to be read, set by the one read port of the element memory.
// The receiver cannot stall. Reset (rst_ni low, asynchronous) empties the queue;
// memory contents are not cleared.
module double_ended_queue_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  dq_pkg::op_t     operation_i,
  input  dq_pkg::word_t   value_i,
  output logic            strobe_o,
  output dq_pkg::status_t status_o,
  output dq_pkg::word_t   element_o,
  output dq_pkg::fill_t   fill_count_o,
  output logic            last_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  dq_pkg::word_t wdata, rdata;

  dq_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .status_o    (status_o),
    .element_o   (element_o),
    .fill_count_o(fill_count_o),
    .last_o      (last_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  dq_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

`ifndef SYNTHESIS
  // Every non-show item answers with a single final result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i != dq_pkg::OP_SHOW) |=> (strobe_o && last_o))
    else $error("non-show item did not answer in one cycle");

  // A full report only comes with a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && status_o == dq_pkg::STAT_FULL) |-> (fill_count_o == CAPACITY))
    else $error("full status with queue not full");

  // Fill count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (fill_count_o <= CAPACITY))
    else $error("fill count above capacity");

  // While a show walk runs, its final result has not yet appeared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !(strobe_o && last_o))
    else $error("final result while still busy");
`endif

endmodule

// ----- sim/deque_checker.sv -----
`timescale 1ns / 100ps

module deque_checker
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    busy_i,
  input  op_t     operation_i,
  input  word_t   value_i,
  input  logic    strobe_i,
  input  status_t status_i,
  input  word_t   element_i,
  input  fill_t   fill_count_i,
  input  logic    last_i,
  output int      fail_count_o,
  output int      outstanding_o
);

  typedef struct packed {
    status_t status;
    word_t   element;
    fill_t   fill;
    logic    last;
  } deque_result_t;

  // Mirror of the queue contents
  word_t       mirror_words [CAPACITY];
  int unsigned mirror_front;
  int unsigned mirror_count;

  deque_result_t awaited_results [$];
  int            mismatches;

  function automatic int unsigned wrap_slot(input int unsigned slot);
    return slot % CAPACITY;
  endfunction

  // Apply one item to the mirror and queue up the results it should produce
  function automatic void predict_deque_op(input op_t op, input word_t word);
    deque_result_t res;
    int unsigned   i;
    res.status  = STAT_OK;
    res.element = '0;
    res.fill    = fill_t'(mirror_count);
    res.last    = 1'b1;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (mirror_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            mirror_front = wrap_slot(mirror_front + CAPACITY - 1);
            mirror_words[mirror_front] = word;
          end else begin
            mirror_words[wrap_slot(mirror_front + mirror_count)] = word;
          end
          mirror_count++;
          res.fill = fill_t'(mirror_count);
        end
        awaited_results.push_back(res);
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (mirror_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) mirror_front = wrap_slot(mirror_front + 1);
          mirror_count--;
          res.fill = fill_t'(mirror_count);
        end
        awaited_results.push_back(res);
      end
      OP_SHOW: begin
        if (mirror_count == 0) begin
          res.status = STAT_EMPTY;
          awaited_results.push_back(res);
        end else begin
          for (i = 0; i < mirror_count; i++) begin
            res.element = mirror_words[wrap_slot(mirror_front + i)];
            res.last    = (i + 1 == mirror_count);
            awaited_results.push_back(res);
          end
        end
      end
      default: begin
        // unused codes leave the queue alone
        awaited_results.push_back(res);
      end
    endcase
  endfunction

  // Compare one result from the block with the oldest expectation
  function automatic void check_result();
    deque_result_t want;
    if (awaited_results.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result: status %0d element %0d fill %0d last %0b",
                 $realtime, status_i, element_i, fill_count_i, last_i);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    if (status_i !== want.status || element_i !== want.element ||
        fill_count_i !== want.fill || last_i !== want.last) begin
      if (mismatches < 10)
        $display({"%0t: result mismatch: want status %0d element %0d fill %0d last %0b,",
                  " got status %0d element %0d fill %0d last %0b"},
                 $realtime, want.status, want.element, want.fill, want.last,
                 status_i, element_i, fill_count_i, last_i);
      mismatches++;
    end
  endfunction

  // Retire results first, then predict the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_front = 0;
      mirror_count = 0;
      awaited_results.delete();
      mismatches = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (strobe_i) check_result();
      if (start_i && !busy_i) predict_deque_op(operation_i, value_i);
      fail_count_o  <= mismatches;
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// ----- sim/double_ended_queue_core_test.sv -----
`timescale 1ns / 100ps

module double_ended_queue_core_test;
  import dq_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int          RANDOM_ITEMS = 440;
  localparam int          IDLE_LIMIT   = 2000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} phase_mode_t;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    start_i     = 1'b0;
  op_t     operation_i = OP_SHOW;
  word_t   value_i     = '0;
  logic    busy_o;
  logic    strobe_o;
  status_t status_o;
  word_t   element_o;
  fill_t   fill_count_o;
  logic    last_o;

  int fail_count;
  int outstanding;
  int idle_cycles;
  bit steady;

  double_ended_queue_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .status_o    (status_o),
    .element_o   (element_o),
    .fill_count_o(fill_count_o),
    .last_o      (last_o)
  );

  deque_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .strobe_i     (strobe_o),
    .status_i     (status_o),
    .element_i    (element_o),
    .fill_count_i (fill_count_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // End the run when neither items nor results move for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || strobe_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, some long ones, none during a steady stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Hold the item on the ports until the block takes it
  task automatic send_item(input op_t op, input word_t word);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i     <= 1'b0;
      operation_i <= op_t'($urandom_range(0, 7));
      value_i     <= word_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= word;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Drop start and wait until every result has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic op_t pick_op(input phase_mode_t mode);
    int unsigned r;
    r = $urandom_range(0, 19);
    case (mode)
      MODE_FILL:  return (r < 9) ? OP_PUSH_BACK : (r < 18) ? OP_PUSH_FRONT : OP_SHOW;
      MODE_DRAIN: return (r < 9) ? OP_POP_BACK : (r < 18) ? OP_POP_FRONT : OP_SHOW;
      default: begin
        if (r == 0) return op_t'($urandom_range(0, 7));
        return op_t'($urandom_range(0, 4));
      end
    endcase
  endfunction

  initial begin
    int          sent;
    int          len;
    int          phase;
    phase_mode_t mode;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, extreme words, front wrap, unused codes
    steady = 1'b0;
    send_item(OP_SHOW,       '0);
    send_item(OP_POP_BACK,   '0);
    send_item(OP_POP_FRONT,  '0);
    send_item(op_t'(5),      32'sh1234_5678);
    send_item(OP_PUSH_BACK,  32'sh7FFF_FFFF);
    send_item(OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(OP_PUSH_BACK,  '0);
    send_item(OP_PUSH_FRONT, -1);
    send_item(OP_SHOW,       '0);
    send_item(op_t'(6),      -1);
    send_item(op_t'(7),      '0);
    send_item(OP_POP_BACK,   -1);
    send_item(OP_SHOW,       '0);
    send_item(OP_POP_FRONT,  '0);
    send_item(OP_SHOW,       '0);
    send_item(OP_PUSH_FRONT, 32'sh5555_5555);
    send_item(OP_PUSH_BACK,  32'shAAAA_AAAA);
    send_item(OP_SHOW,       '0);
    send_item(OP_POP_FRONT,  '0);
    send_item(OP_POP_BACK,   '0);
    send_item(OP_POP_BACK,   '0);
    send_item(OP_POP_FRONT,  '0);
    send_item(OP_POP_BACK,   '0);
    send_item(OP_SHOW,       '0);

    // Random phases: fill past full, drain past empty, then free mix
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) mode = MODE_FILL;
      else if (phase == 1) mode = MODE_DRAIN;
      else mode = phase_mode_t'($urandom_range(0, 2));
      len    = (mode == MODE_MIXED) ? $urandom_range(20, 60) : $urandom_range(72, 80);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      steady = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        send_item(pick_op(mode), pick_word());
        sent++;
      end
      if (phase == 0 || $urandom_range(0, 2) == 0) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
